>>> hw/rtl/odhp_pkg.sv
`timescale 1ns / 1ps
// odhp_pkg: widths, constants and types shared by the omni-drive heading PID block.
// No dependencies; imported by odhp_mac and omni_drive_heading_pid_top.
package odhp_pkg;

    localparam int TOTAL_WIDTH = 32;
    localparam int ENC_CENTER  = 32767;

    localparam int STICK_W  = 7;
    localparam int ENC_W    = 16;
    localparam int AXIS_W   = 10;
    localparam int DELTA_W  = 19;
    localparam int ERR_W    = TOTAL_WIDTH + 1;
    localparam int INT_W    = 48;
    localparam int HEAD_W   = 10;

    localparam int GAIN_W   = 20;
    localparam int DZ_W     = 7;
    localparam int LIM_W    = 9;
    localparam int CPH_W    = 22;
    localparam int CENTER_W = 9;
    localparam int SPAN_W   = 8;

    localparam int Q_W      = HEAD_W + CPH_W;
    localparam int CHUNK_W  = 24;
    localparam int MUL_A_W  = CHUNK_W + 1;
    localparam int MUL_B_W  = CPH_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 3 * CHUNK_W;

    localparam int SIN60_Q16   = 56756;
    localparam int PID_SAT     = 1 << 30;
    localparam int PID_W       = 32;
    localparam int YSIN_W      = 24;
    localparam int SPD_W       = 26;
    localparam int S_W         = 2 * CHUNK_W;
    localparam int PULSE_SHIFT = 23;
    localparam int PULSE_W     = 10;
    localparam int COUNT_W     = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    typedef struct packed {
        logic [STICK_W-1:0] stick_x_raw;
        logic [STICK_W-1:0] stick_y_raw;
        logic               turn_ccw_button;
        logic               turn_cw_button;
        logic [ENC_W-1:0]   enc_first;
        logic [ENC_W-1:0]   enc_second;
        logic [ENC_W-1:0]   enc_third;
    } t_in;

    typedef struct packed {
        logic [PULSE_W-1:0]        wheel_a_pos_pulse;
        logic [PULSE_W-1:0]        wheel_a_neg_pulse;
        logic [PULSE_W-1:0]        wheel_b_pos_pulse;
        logic [PULSE_W-1:0]        wheel_b_neg_pulse;
        logic [PULSE_W-1:0]        wheel_c_pos_pulse;
        logic [PULSE_W-1:0]        wheel_c_neg_pulse;
        logic signed [COUNT_W-1:0] count_total;
    } t_out;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB,
        ACC_NEG
    } t_acc_op;

    typedef enum logic [1:0] {
        SH_0,
        SH_24,
        SH_48
    } t_acc_sh;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
        t_acc_op                   op;
        t_acc_sh                   sh;
    } t_mac_ctl;

    typedef struct packed {
        logic tot_upd;
        logic dead_ld;
        logic q_ld;
        logic ysin_ld;
        logic err_ld;
        logic int_upd;
        logic pid_ld;
        logic wheel_clr;
        logic s_ld;
        logic pos_ld;
        logic neg_ld;
        logic wheel_inc;
        logic out_ld;
    } t_seq_ctl;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_DZ,
        ST_HEAD,
        ST_SIN,
        ST_DELTA,
        ST_ERR0,
        ST_ERR1,
        ST_ERR2,
        ST_INT0,
        ST_INT1,
        ST_PID,
        ST_SAT,
        ST_WSPEED,
        ST_WLO,
        ST_WHI,
        ST_WACC,
        ST_WPOS,
        ST_WNEG,
        ST_DONE
    } t_state;

endpackage

>>> hw/rtl/odhp_mac.sv
`timescale 1ns / 1ps
// odhp_mac: shared 25x23 signed multiplier with a registered product and a
// 72-bit accumulator. Depends on odhp_pkg.
module odhp_mac (
    input  logic                              i_clk,
    input  odhp_pkg::t_mac_ctl                i_ctl,
    output logic signed [odhp_pkg::PROD_W-1:0] o_prod,
    output logic signed [odhp_pkg::ACC_W-1:0]  o_acc
);
    import odhp_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  prod_sh;

    assign n_prod   = i_ctl.a * i_ctl.b;
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        case (i_ctl.sh)
            SH_0:    prod_sh = prod_ext;
            SH_24:   prod_sh = prod_ext << CHUNK_W;
            SH_48:   prod_sh = prod_ext << (2 * CHUNK_W);
            default: prod_sh = prod_ext;
        endcase
    end

    always_comb begin
        case (i_ctl.op)
            ACC_HOLD: n_acc = r_acc;
            ACC_LOAD: n_acc = prod_sh;
            ACC_ADD:  n_acc = r_acc + prod_sh;
            ACC_SUB:  n_acc = r_acc - prod_sh;
            ACC_NEG:  n_acc = -r_acc;
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

>>> hw/rtl/omni_drive_heading_pid_top.sv
`timescale 1ns / 1ps
// omni_drive_heading_pid_top: three-wheel omni-drive mixer with heading-hold PID.
// Depends on odhp_pkg and odhp_mac.
//
// One input transfer is one control tick: stick axes, heading buttons and three
// encoder counts. One output transfer follows per tick: six complementary pulse
// widths and the running encoder total.
// Input channel: i_in_valid / o_in_stall; a transfer happens when valid is high
// and stall low. Output channel: o_out_valid / i_out_stall, same rule.
// Config: write i_cfg_data to register i_cfg_idx when i_cfg_we is high, only
// while no tick is in flight.
// Ticks: a new tick is taken once the previous result has been loaded into the
// output register. All multiplies (deadzone, heading scale, PID sum in 24-bit
// slices, pulse scaling) go through the single 25x23 multiplier and accumulator,
// one product per cycle.
// Output register: a new tick is taken while a result waits; if the receiver
// still stalls when the next result is ready, the block holds it until the
// output register frees.
// Reset (synchronous, active low): registers return to defaults, encoder total,
// integral and heading clear, both channels go idle.
module omni_drive_heading_pid_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  odhp_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output odhp_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [odhp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [odhp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import odhp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DZ     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIM    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CPH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 3'd7;

    localparam int AXIS_OFS = 128;
    localparam int T_W      = ACC_W - PULSE_SHIFT + 1;
    localparam int PQ_W     = ACC_W - 16;

    // config
    logic [GAIN_W-1:0]   r_kp, r_ki, r_kd;
    logic [DZ_W-1:0]     r_dz;
    logic [LIM_W-1:0]    r_lim;
    logic [CPH_W-1:0]    r_cphu;
    logic [CENTER_W-1:0] r_center;
    logic [SPAN_W-1:0]   r_span;

    // control and architectural state
    t_state                        r_state, n_state;
    logic                          r_out_valid;
    logic [1:0]                    r_wheel;
    logic signed [TOTAL_WIDTH-1:0] r_total;
    logic signed [INT_W-1:0]       r_int;
    logic signed [HEAD_W-1:0]      r_heading;
    logic signed [HEAD_W-1:0]      n_heading;

    // working registers
    logic signed [AXIS_W-1:0]  r_x, r_y, n_x, n_y;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    logic                      r_dead;
    logic signed [Q_W-1:0]     r_q;
    logic signed [YSIN_W-1:0]  r_ysin;
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [PID_W-1:0]   r_pid, n_pid;
    logic signed [S_W-1:0]     r_s, n_s;
    logic [PULSE_W-1:0]        r_pos [3];
    logic [PULSE_W-1:0]        r_neg [3];
    t_out                      r_out;

    t_seq_ctl                  ctl;
    t_mac_ctl                  mac_ctl;
    logic signed [ACC_W-1:0]   acc;
    logic signed [PROD_W-1:0]  prod;

    logic                      in_xfer;
    logic                      out_free;
    logic                      dead_now;
    logic signed [AXIS_W-1:0]  y_eff, x_eff;
    logic signed [ACC_W-1:0]   err_ext;
    logic [63:0]               tot_ext;

    function automatic logic [PULSE_W-1:0] pulse_w(
        input logic signed [ACC_W-1:0] a,
        input logic [CENTER_W-1:0]     c
    );
        logic signed [T_W-1:0] t;
        logic signed [T_W-1:0] top;
        logic [PULSE_W-1:0]    res;
        t   = $signed({a[ACC_W-1], a[ACC_W-1:PULSE_SHIFT]})
              + $signed({{(T_W-CENTER_W){1'b0}}, c});
        top = $signed({{(T_W-CENTER_W-1){1'b0}}, c, 1'b0});
        if (t < 0) begin
            res = '0;
        end else if (t > top) begin
            res = {c, 1'b0};
        end else begin
            res = t[PULSE_W-1:0];
        end
        return res;
    endfunction

    odhp_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .o_prod (prod),
        .o_acc  (acc)
    );

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // input-side arithmetic
    assign n_x = {2'b00, i_in_data.stick_x_raw, 1'b0} - AXIS_W'(AXIS_OFS);
    assign n_y = AXIS_W'(AXIS_OFS) - {2'b00, i_in_data.stick_y_raw, 1'b0};
    assign n_delta = DELTA_W'(ENC_CENTER)
                   - {{(DELTA_W-ENC_W){1'b0}}, i_in_data.enc_first}
                   - {{(DELTA_W-ENC_W){1'b0}}, i_in_data.enc_second}
                   + {{(DELTA_W-ENC_W){1'b0}}, i_in_data.enc_third};

    always_comb begin
        logic signed [HEAD_W:0] h_lim;
        logic signed [HEAD_W:0] h_up;
        logic signed [HEAD_W:0] h_dn;
        h_lim = $signed({2'b00, r_lim});
        h_up  = {r_heading[HEAD_W-1], r_heading}
              + {{HEAD_W{1'b0}}, i_in_data.turn_ccw_button};
        if (i_in_data.turn_ccw_button && (h_up > h_lim)) begin
            h_up = h_lim;
        end
        h_dn = h_up - {{HEAD_W{1'b0}}, i_in_data.turn_cw_button};
        if (i_in_data.turn_cw_button && (h_dn < -h_lim)) begin
            h_dn = -h_lim;
        end
        n_heading = h_dn[HEAD_W-1:0];
    end

    assign dead_now = acc[ACC_W-1];
    assign y_eff    = dead_now ? '0 : r_y;
    assign x_eff    = r_dead ? '0 : r_x;
    assign err_ext  = {{(ACC_W-ERR_W){r_err[ERR_W-1]}}, r_err};
    assign tot_ext  = {{(64-TOTAL_WIDTH){r_total[TOTAL_WIDTH-1]}}, r_total};

    // trunc(total - q/65536)
    always_comb begin
        logic signed [ERR_W-1:0] f_ext;
        logic signed [ERR_W-1:0] tf;
        f_ext = {{(ERR_W-(Q_W-16)){r_q[Q_W-1]}}, r_q[Q_W-1:16]};
        tf    = {r_total[TOTAL_WIDTH-1], r_total} - f_ext;
        if ((|r_q[15:0]) && !tf[ERR_W-1] && (|tf)) begin
            n_err = tf - ERR_W'(1);
        end else begin
            n_err = tf;
        end
    end

    // trunc(acc/65536), saturated
    always_comb begin
        logic signed [PQ_W-1:0] pq;
        pq = acc[ACC_W-1:16] + {{(PQ_W-1){1'b0}}, (acc[ACC_W-1] && (|acc[15:0]))};
        if (pq > $signed(PQ_W'(PID_SAT))) begin
            n_pid = PID_W'(PID_SAT);
        end else if (pq < -$signed(PQ_W'(PID_SAT))) begin
            n_pid = -PID_W'(PID_SAT);
        end else begin
            n_pid = pq[PID_W-1:0];
        end
    end

    // wheel speed minus PID, Q16
    always_comb begin
        logic signed [SPD_W-1:0] x_half;
        logic signed [SPD_W-1:0] x_full;
        logic signed [SPD_W-1:0] ys;
        logic signed [SPD_W-1:0] sp;
        x_half = {{(SPD_W-AXIS_W-15){x_eff[AXIS_W-1]}}, x_eff, 15'b0};
        x_full = {x_eff, 16'b0};
        ys     = {{(SPD_W-YSIN_W){r_ysin[YSIN_W-1]}}, r_ysin};
        case (r_wheel)
            2'd0:    sp = -x_full;
            2'd1:    sp = x_half - ys;
            default: sp = x_half + ys;
        endcase
        n_s = {{(S_W-SPD_W){sp[SPD_W-1]}}, sp} - {r_pid, 16'b0};
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_xfer) n_state = ST_SQ_X;
            ST_SQ_X:   n_state = ST_SQ_Y;
            ST_SQ_Y:   n_state = ST_SQ_DZ;
            ST_SQ_DZ:  n_state = ST_HEAD;
            ST_HEAD:   n_state = ST_SIN;
            ST_SIN:    n_state = ST_DELTA;
            ST_DELTA:  n_state = ST_ERR0;
            ST_ERR0:   n_state = ST_ERR1;
            ST_ERR1:   n_state = ST_ERR2;
            ST_ERR2:   n_state = ST_INT0;
            ST_INT0:   n_state = ST_INT1;
            ST_INT1:   n_state = ST_PID;
            ST_PID:    n_state = ST_SAT;
            ST_SAT:    n_state = ST_WSPEED;
            ST_WSPEED: n_state = ST_WLO;
            ST_WLO:    n_state = ST_WHI;
            ST_WHI:    n_state = ST_WACC;
            ST_WACC:   n_state = ST_WPOS;
            ST_WPOS:   n_state = ST_WNEG;
            ST_WNEG:   n_state = (r_wheel == 2'd2) ? ST_DONE : ST_WSPEED;
            ST_DONE:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer: outputs (operands issued now, accumulate the product issued last cycle)
    always_comb begin
        ctl        = '0;
        mac_ctl.a  = '0;
        mac_ctl.b  = '0;
        mac_ctl.op = ACC_HOLD;
        mac_ctl.sh = SH_0;
        case (r_state)
            ST_SQ_X: begin
                ctl.tot_upd = 1'b1;
                mac_ctl.a   = {{(MUL_A_W-AXIS_W){r_x[AXIS_W-1]}}, r_x};
                mac_ctl.b   = {{(MUL_B_W-AXIS_W){r_x[AXIS_W-1]}}, r_x};
            end
            ST_SQ_Y: begin
                mac_ctl.a  = {{(MUL_A_W-AXIS_W){r_y[AXIS_W-1]}}, r_y};
                mac_ctl.b  = {{(MUL_B_W-AXIS_W){r_y[AXIS_W-1]}}, r_y};
                mac_ctl.op = ACC_LOAD;
            end
            ST_SQ_DZ: begin
                mac_ctl.a  = {{(MUL_A_W-DZ_W){1'b0}}, r_dz};
                mac_ctl.b  = {{(MUL_B_W-DZ_W){1'b0}}, r_dz};
                mac_ctl.op = ACC_ADD;
            end
            ST_HEAD: begin
                mac_ctl.a  = {{(MUL_A_W-HEAD_W){r_heading[HEAD_W-1]}}, r_heading};
                mac_ctl.b  = {1'b0, r_cphu};
                mac_ctl.op = ACC_SUB;
            end
            ST_SIN: begin
                ctl.dead_ld = 1'b1;
                ctl.q_ld    = 1'b1;
                mac_ctl.a   = {{(MUL_A_W-AXIS_W){y_eff[AXIS_W-1]}}, y_eff};
                mac_ctl.b   = MUL_B_W'(SIN60_Q16);
            end
            ST_DELTA: begin
                ctl.ysin_ld = 1'b1;
                ctl.err_ld  = 1'b1;
                mac_ctl.a   = {{(MUL_A_W-DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
                mac_ctl.b   = {{(MUL_B_W-GAIN_W){1'b0}}, r_kd};
            end
            ST_ERR0: begin
                ctl.int_upd = 1'b1;
                mac_ctl.a   = {1'b0, err_ext[CHUNK_W-1:0]};
                mac_ctl.b   = {{(MUL_B_W-GAIN_W){1'b0}}, r_kp};
                mac_ctl.op  = ACC_LOAD;
            end
            ST_ERR1: begin
                mac_ctl.a  = {1'b0, err_ext[2*CHUNK_W-1:CHUNK_W]};
                mac_ctl.b  = {{(MUL_B_W-GAIN_W){1'b0}}, r_kp};
                mac_ctl.op = ACC_ADD;
            end
            ST_ERR2: begin
                mac_ctl.a  = {err_ext[ACC_W-1], err_ext[ACC_W-1:2*CHUNK_W]};
                mac_ctl.b  = {{(MUL_B_W-GAIN_W){1'b0}}, r_kp};
                mac_ctl.op = ACC_ADD;
                mac_ctl.sh = SH_24;
            end
            ST_INT0: begin
                mac_ctl.a  = {1'b0, r_int[CHUNK_W-1:0]};
                mac_ctl.b  = {{(MUL_B_W-GAIN_W){1'b0}}, r_ki};
                mac_ctl.op = ACC_ADD;
                mac_ctl.sh = SH_48;
            end
            ST_INT1: begin
                mac_ctl.a  = {r_int[INT_W-1], r_int[INT_W-1:CHUNK_W]};
                mac_ctl.b  = {{(MUL_B_W-GAIN_W){1'b0}}, r_ki};
                mac_ctl.op = ACC_ADD;
            end
            ST_PID: begin
                mac_ctl.op = ACC_ADD;
                mac_ctl.sh = SH_24;
            end
            ST_SAT: begin
                ctl.pid_ld    = 1'b1;
                ctl.wheel_clr = 1'b1;
            end
            ST_WSPEED: begin
                ctl.s_ld = 1'b1;
            end
            ST_WLO: begin
                mac_ctl.a = {1'b0, r_s[CHUNK_W-1:0]};
                mac_ctl.b = {{(MUL_B_W-SPAN_W){1'b0}}, r_span};
            end
            ST_WHI: begin
                mac_ctl.a  = {r_s[S_W-1], r_s[S_W-1:CHUNK_W]};
                mac_ctl.b  = {{(MUL_B_W-SPAN_W){1'b0}}, r_span};
                mac_ctl.op = ACC_LOAD;
            end
            ST_WACC: begin
                mac_ctl.op = ACC_ADD;
                mac_ctl.sh = SH_24;
            end
            ST_WPOS: begin
                ctl.pos_ld = 1'b1;
                mac_ctl.op = ACC_NEG;
            end
            ST_WNEG: begin
                ctl.neg_ld    = 1'b1;
                ctl.wheel_inc = 1'b1;
            end
            ST_DONE: begin
                ctl.out_ld = out_free;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    // control, config and tick state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_wheel     <= 2'd0;
            r_total     <= '0;
            r_int       <= '0;
            r_heading   <= '0;
            r_kp        <= GAIN_W'(13107);
            r_ki        <= '0;
            r_kd        <= GAIN_W'(66);
            r_dz        <= DZ_W'(20);
            r_lim       <= LIM_W'(314);
            r_cphu      <= CPH_W'(152768);
            r_center    <= CENTER_W'(160);
            r_span      <= SPAN_W'(75);
        end else begin
            r_state <= n_state;
            if (ctl.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (ctl.wheel_clr) begin
                r_wheel <= 2'd0;
            end else if (ctl.wheel_inc) begin
                r_wheel <= r_wheel + 2'd1;
            end
            if (in_xfer) begin
                r_heading <= n_heading;
            end
            if (ctl.tot_upd) begin
                r_total <= r_total
                         + {{(TOTAL_WIDTH-DELTA_W){r_delta[DELTA_W-1]}}, r_delta};
            end
            if (ctl.int_upd) begin
                r_int <= r_int + {{(INT_W-ERR_W){r_err[ERR_W-1]}}, r_err};
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KP:     r_kp     <= i_cfg_data[GAIN_W-1:0];
                    CFG_KI:     r_ki     <= i_cfg_data[GAIN_W-1:0];
                    CFG_KD:     r_kd     <= i_cfg_data[GAIN_W-1:0];
                    CFG_DZ:     r_dz     <= i_cfg_data[DZ_W-1:0];
                    CFG_LIM:    r_lim    <= i_cfg_data[LIM_W-1:0];
                    CFG_CPH:    r_cphu   <= i_cfg_data[CPH_W-1:0];
                    CFG_CENTER: r_center <= i_cfg_data[CENTER_W-1:0];
                    CFG_SPAN:   r_span   <= i_cfg_data[SPAN_W-1:0];
                    default:    r_kp     <= r_kp;
                endcase
            end
        end
    end

    // datapath; q and y*sin60 are taken straight from the product register
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x     <= n_x;
            r_y     <= n_y;
            r_delta <= n_delta;
        end
        if (ctl.dead_ld) r_dead <= dead_now;
        if (ctl.q_ld)    r_q    <= prod[Q_W-1:0];
        if (ctl.ysin_ld) r_ysin <= prod[YSIN_W-1:0];
        if (ctl.err_ld)  r_err  <= n_err;
        if (ctl.pid_ld)  r_pid  <= n_pid;
        if (ctl.s_ld)    r_s    <= n_s;
        if (ctl.pos_ld)  r_pos[r_wheel] <= pulse_w(acc, r_center);
        if (ctl.neg_ld)  r_neg[r_wheel] <= pulse_w(acc, r_center);
        if (ctl.out_ld) begin
            r_out.wheel_a_pos_pulse <= r_pos[0];
            r_out.wheel_a_neg_pulse <= r_neg[0];
            r_out.wheel_b_pos_pulse <= r_pos[1];
            r_out.wheel_b_neg_pulse <= r_neg[1];
            r_out.wheel_c_pos_pulse <= r_pos[2];
            r_out.wheel_c_neg_pulse <= r_neg[2];
            r_out.count_total       <= tot_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
